@@ rtl/psrc_pkg.sv @@
// psrc_pkg: shared types and constants for the pair sum range counter
// used by psrc_cell, psrc_tally and pair_sum_range_count_unit; no dependencies
package psrc_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 15;
   localparam logic [CountWidth-1:0] CountMax = 15'h7fff;

   // register indexes on the csr port
   localparam logic [0:0] CsrLowerBound = 1'b0;
   localparam logic [0:0] CsrUpperBound = 1'b1;

   // one item travelling down the chain of cells
   typedef struct packed {
      logic                         valid;
      logic                         last;
      logic                         store;   // still looking for a free cell
      logic                         drop;    // store was full at entry
      logic signed [ValueWidth-1:0] value;
      logic [CountWidth-1:0]        count;   // pairs found so far for this item
   } token_type;

   // sum window shared by every cell
   typedef struct packed {
      logic signed [ValueWidth-1:0] lower;
      logic signed [ValueWidth-1:0] upper;
      logic                         reversed;
   } bounds_type;

endpackage

@@ rtl/psrc_cell.sv @@
// psrc_cell: one stage of the compare chain, holds one stored value
// depends on psrc_pkg (token_type, bounds_type)
module psrc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  psrc_pkg::bounds_type  bounds,
   input  psrc_pkg::token_type   tok_i,
   output psrc_pkg::token_type   tok_o
);

   logic                                   occ_ff, occ_in;
   logic signed [psrc_pkg::ValueWidth-1:0] value_ff, value_in;
   psrc_pkg::token_type                    tok_ff, tok_in;

   logic signed [psrc_pkg::ValueWidth:0] sum;
   logic signed [psrc_pkg::ValueWidth:0] lower_ext;
   logic signed [psrc_pkg::ValueWidth:0] upper_ext;
   logic ge_lo, le_hi, in_window, hit, take;

   always_comb begin
      // exact 33-bit pair sum, no wrap
      sum       = {value_ff[psrc_pkg::ValueWidth-1], value_ff}
                + {tok_i.value[psrc_pkg::ValueWidth-1], tok_i.value};
      lower_ext = {bounds.lower[psrc_pkg::ValueWidth-1], bounds.lower};
      upper_ext = {bounds.upper[psrc_pkg::ValueWidth-1], bounds.upper};
      ge_lo     = sum >= lower_ext;
      le_hi     = sum <= upper_ext;
      // reversed window counts the open gap between the bounds
      in_window = bounds.reversed ? (!ge_lo && !le_hi) : (ge_lo && le_hi);
      hit       = tok_i.valid && occ_ff && !tok_i.drop && in_window;
      take      = tok_i.valid && tok_i.store && !occ_ff;

      tok_in       = tok_i;
      tok_in.count = tok_i.count + psrc_pkg::CountWidth'(hit);
      tok_in.store = tok_i.store && occ_ff;

      value_in = take ? tok_i.value : value_ff;
      if (tok_i.valid && tok_i.last) begin
         occ_in = 1'b0;   // end of set empties the chain behind it
      end else if (take) begin
         occ_in = 1'b1;
      end else begin
         occ_in = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         tok_ff <= '0;
      end else if (adv) begin
         occ_ff <= occ_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= value_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

@@ rtl/psrc_tally.sv @@
// psrc_tally: sums per-item pair counts leaving the chain and holds the result
// depends on psrc_pkg (token_type, CountMax)
module psrc_tally (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  psrc_pkg::token_type                 tok_i,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [psrc_pkg::CountWidth-1:0]     rsp_count,
   output logic                                rsp_overflow
);

   logic [psrc_pkg::CountWidth-1:0] acc_ff, acc_in;
   logic                            dropped_ff, dropped_in;
   logic                            valid_ff, valid_in;
   logic [psrc_pkg::CountWidth-1:0] count_ff, count_in;
   logic                            ovf_ff, ovf_in;
   logic [psrc_pkg::CountWidth:0]   wide_sum;
   logic [psrc_pkg::CountWidth-1:0] sat_sum;

   always_comb begin
      wide_sum = {1'b0, acc_ff} + {1'b0, tok_i.count};
      sat_sum  = wide_sum[psrc_pkg::CountWidth] ? psrc_pkg::CountMax
                                                 : wide_sum[psrc_pkg::CountWidth-1:0];
      acc_in     = acc_ff;
      dropped_in = dropped_ff;
      valid_in   = valid_ff && !rsp_ready;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      if (adv && tok_i.valid) begin
         if (tok_i.last) begin
            valid_in   = 1'b1;
            count_in   = sat_sum;
            ovf_in     = dropped_ff || tok_i.drop;
            acc_in     = '0;
            dropped_in = 1'b0;
         end else begin
            acc_in     = sat_sum;
            dropped_in = dropped_ff || tok_i.drop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         dropped_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         dropped_ff <= dropped_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_count    = count_ff;
   assign rsp_overflow = ovf_ff;

endmodule

@@ rtl/pair_sum_range_count_unit.sv @@
// pair_sum_range_count_unit: top level of the pair sum range counter
// depends on psrc_pkg, psrc_cell and psrc_tally
//
// usage
//  - req_ channel: one signed 32-bit value per transfer, req_tlast marks the
//    final value of a set
//  - rsp_ channel: one transfer per set, issued for the value marked last;
//    pair_count in rsp_tdata, overflow flag in rsp_tuser
//  - csr_ port: index 0 lower bound, index 1 upper bound, written while idle
//  - each value walks a chain of MAX_ITEMS cells, one cell per cycle while not stalled, and is
//    compared with the value stored in every occupied cell on its way; it
//    settles in the first free cell, the last value of a set empties the
//    cells as it passes, so the next set can follow straight behind it
//  - throughput: one value per cycle while the chain is not stalled; the last
//    transfer passes every cell register, then the tally register, to rsp_tvalid
//  - values beyond MAX_ITEMS in one set are dropped and flagged in overflow
//  - reset empties every cell, zeroes the bounds and the running count
//  - a stalled receiver only holds up the chain when a finished result is
//    still waiting and the next one reaches the end of the chain
module pair_sum_range_count_unit #(
   parameter int MAX_ITEMS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [14:0] pair_count, [15] zero
   output logic        rsp_tuser,    // [0] overflow
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int FillWidth = $clog2(MAX_ITEMS + 1);
   localparam logic [FillWidth-1:0] FillFull = FillWidth'(MAX_ITEMS);

   // configuration registers
   logic signed [31:0] lower_ff, lower_in;
   logic signed [31:0] upper_ff, upper_in;
   psrc_pkg::bounds_type bounds;

   // entry side
   logic [FillWidth-1:0] fill_ff, fill_in;
   logic                 req_fire;
   logic                 entry_drop;
   logic                 adv;

   psrc_pkg::token_type tok_chain [0:MAX_ITEMS];
   psrc_pkg::token_type exit_tok;

   logic [psrc_pkg::CountWidth-1:0] rsp_count;
   logic                            rsp_overflow;

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_we) begin
         unique case (csr_index)
            psrc_pkg::CsrLowerBound: lower_in = csr_wdata;
            psrc_pkg::CsrUpperBound: upper_in = csr_wdata;
            default: begin
               lower_in = lower_ff;
               upper_in = upper_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   assign bounds.lower    = lower_ff;
   assign bounds.upper    = upper_ff;
   assign bounds.reversed = lower_ff > upper_ff;

   // chain moves unless a result still waits and another one is due
   assign exit_tok   = tok_chain[MAX_ITEMS];
   assign adv        = !(exit_tok.valid && exit_tok.last && rsp_tvalid && !rsp_tready);
   assign req_tready = adv;
   assign req_fire   = req_tvalid && adv;
   assign entry_drop = fill_ff == FillFull;

   always_comb begin
      fill_in = fill_ff;
      if (req_fire) begin
         if (req_tlast) begin
            fill_in = '0;
         end else if (!entry_drop) begin
            fill_in = fill_ff + FillWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // new item entering the head of the chain
   always_comb begin
      tok_chain[0].valid = req_fire;
      tok_chain[0].last  = req_tlast;
      tok_chain[0].drop  = entry_drop;
      tok_chain[0].store = !entry_drop && !req_tlast;
      tok_chain[0].value = req_tdata;
      tok_chain[0].count = '0;
   end

   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      psrc_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .bounds (bounds),
         .tok_i  (tok_chain[g]),
         .tok_o  (tok_chain[g+1])
      );
   end

   psrc_tally u_tally (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .tok_i        (exit_tok),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_count    (rsp_count),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata = {1'b0, rsp_count};
   assign rsp_tuser = rsp_overflow;

   // fill count never passes the number of cells
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FillFull)
      else $error("fill count beyond capacity");

   // the end of a set always restarts the fill count
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> fill_ff == '0)
      else $error("fill count not cleared after last transfer");

   // the chain only stops while a finished result is held by the receiver
   assert property (@(posedge clock) disable iff (reset)
      !adv |-> (rsp_tvalid && !rsp_tready))
      else $error("chain stalled without a waiting result");

   // a result leaves the tally only when the chain delivered a last item
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid ##1 rsp_tvalid) |-> $past(exit_tok.valid && exit_tok.last))
      else $error("result raised without a last item");

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for pair_sum_range_count_unit, sets of values in, pair counts out
// depends on psrc_pkg and the unit; expected counts come from an in-bench model of the pair search
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxItems   = 256;
   localparam int ItemTarget = 1500;
   // past this many transfers both sides run without gaps
   localparam int CalmAfter  = 1300;
   // cycles without any transfer before the run is declared hung
   localparam int QuietLimit = 20 * MaxItems + 2000;
   // chain length plus margin, waited out before a bound changes and at the end
   localparam int Drain      = MaxItems + 16;
   localparam logic signed [31:0] MinValue = 32'sh8000_0000;
   localparam logic signed [31:0] MaxValue = 32'sh7fff_ffff;

   // how the values of a set are spread
   typedef enum int {NearZero, AnyValue, Corners} spread_type;
   // shape of the sum window
   typedef enum int {BoundsNarrow, BoundsWide, BoundsReversed, BoundsExtreme} window_type;

   // model of the unit plus the queue of counts still to arrive
   class pair_ledger_type;
      logic signed [31:0]              lower;
      logic signed [31:0]              upper;
      logic signed [31:0]              held[$];
      logic [psrc_pkg::CountWidth-1:0] pairs;
      logic                            dropped;
      int                              capacity;
      logic [psrc_pkg::CountWidth:0]   awaited[$];   // {overflow, pair_count}
      int                              failures;

      function new(int depth);
         capacity = depth;
         lower    = '0;
         upper    = '0;
         pairs    = '0;
         dropped  = 1'b0;
         failures = 0;
      endfunction

      function void set_bound(logic [0:0] index, logic [31:0] data);
         if (index == psrc_pkg::CsrLowerBound) lower = data;
         else if (index == psrc_pkg::CsrUpperBound) upper = data;
      endfunction

      // a reversed window counts the sums strictly between the two bounds
      function bit in_window(logic signed [32:0] total);
         if (lower <= upper) return total >= lower && total <= upper;
         return total > upper && total < lower;
      endfunction

      function void note_value(logic signed [31:0] value, logic last);
         logic signed [32:0] total;
         if (held.size() < capacity) begin
            foreach (held[k]) begin
               // 33-bit sum, never wraps
               total = {held[k][31], held[k]} + {value[31], value};
               if (in_window(total) && pairs != psrc_pkg::CountMax) pairs++;
            end
            held.push_back(value);
         end else begin
            dropped = 1'b1;
         end
         if (last) begin
            awaited.push_back({dropped, pairs});
            held.delete();
            pairs   = '0;
            dropped = 1'b0;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report(string what);
         failures++;
         if (failures <= 100) $display("%0t mismatch: %s", $time, what);
      endtask

      task check_count(logic [psrc_pkg::CountWidth-1:0] count, logic overflow, logic pad);
         logic [psrc_pkg::CountWidth:0] want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result, count %0d overflow %0b", count, overflow));
            return;
         end
         want = awaited.pop_front();
         if (count !== want[psrc_pkg::CountWidth-1:0])
            report($sformatf("pair_count %0d, expected %0d",
                             count, want[psrc_pkg::CountWidth-1:0]));
         if (overflow !== want[psrc_pkg::CountWidth])
            report($sformatf("overflow %0b, expected %0b",
                             overflow, want[psrc_pkg::CountWidth]));
         if (pad !== 1'b0)
            report($sformatf("rsp_tdata padding bit is %0b", pad));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [31:0] value
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [14:0] pair_count, [15] zero
   logic        rsp_tuser;          // [0] overflow
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   // gap switches for the two sides, and transfers accepted on the input side
   bit feed_gaps = 1'b1;
   bit rsp_gaps  = 1'b1;
   int sent      = 0;

   pair_ledger_type ledger = new(MaxItems);

   pair_sum_range_count_unit #(.MAX_ITEMS(MaxItems)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // one transfer on the input side; valid stays high so the next value can follow
   // straight on, a gap lowers it first
   task automatic send_value(logic signed [31:0] value, logic last);
      @(negedge clock);
      if (feed_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      ledger.note_value(value, last);
      sent++;
   endtask

   task automatic hold_feed();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_bound(logic [0:0] index, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      ledger.set_bound(index, data);
   endtask

   // every count in, then let the chain run empty
   task automatic settle();
      while (ledger.pending() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value(spread_type spread);
      unique case (spread)
         NearZero: return $urandom_range(0, 80) - 40;
         Corners: begin
            unique case ($urandom_range(0, 6))
               0: return MinValue;
               1: return MaxValue;
               2: return MinValue + 1;
               3: return MaxValue - 1;
               4: return 0;
               5: return -1;
               default: return $urandom;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic run_set(int len, spread_type spread);
      for (int i = 1; i <= len; i++) send_value(pick_value(spread), i == len);
   endtask

   // sample results before the edge updates them
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_count(rsp_tdata[psrc_pkg::CountWidth-1:0], rsp_tuser, rsp_tdata[15]);
   end

   // receiver: ready with bursts of back-pressure while gaps are on
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (rsp_gaps && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: any transfer on either side restarts the quiet count
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int                 len;
      int                 sets;
      spread_type         spread;
      window_type         shape;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic signed [31:0] swap;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bounds come out of reset at zero: only sums of exactly zero count
      send_value(5, 1'b0);
      send_value(-5, 1'b0);
      send_value(0, 1'b0);
      send_value(0, 1'b1);
      // a set of one value has no pairs
      send_value(MaxValue, 1'b1);
      hold_feed();
      settle();

      // widest window: only sums outside the 32-bit range miss
      write_bound(psrc_pkg::CsrLowerBound, MinValue);
      write_bound(psrc_pkg::CsrUpperBound, MaxValue);
      send_value(MinValue, 1'b0);
      send_value(MinValue, 1'b0);
      send_value(MaxValue, 1'b0);
      send_value(MaxValue, 1'b0);
      send_value(-1, 1'b0);
      send_value(1, 1'b1);
      hold_feed();
      settle();

      // reversed window: lower above upper, both ends excluded
      write_bound(psrc_pkg::CsrLowerBound, 10);
      write_bound(psrc_pkg::CsrUpperBound, -10);
      send_value(0, 1'b0);
      send_value(10, 1'b0);
      send_value(-10, 1'b0);
      send_value(9, 1'b0);
      send_value(-20, 1'b1);
      hold_feed();
      settle();

      // store full: the values past capacity are dropped, the last one included,
      // and the count still comes out with overflow set
      write_bound(psrc_pkg::CsrLowerBound, -3);
      write_bound(psrc_pkg::CsrUpperBound, 3);
      run_set(MaxItems + 2, NearZero);
      hold_feed();
      settle();

      // random phases: fresh window, then a run of sets at one setting
      while (sent < ItemTarget) begin
         shape = window_type'($urandom_range(0, 3));
         lo    = $urandom;
         hi    = $urandom;
         unique case (shape)
            BoundsNarrow: begin
               lo = 0 - $urandom_range(0, 60);
               hi = $urandom_range(0, 60);
            end
            BoundsWide: begin
               if (lo > hi) begin
                  swap = lo;
                  lo   = hi;
                  hi   = swap;
               end
            end
            BoundsReversed: begin
               if (lo < hi) begin
                  swap = lo;
                  lo   = hi;
                  hi   = swap;
               end
            end
            default: begin
               lo = $urandom_range(0, 1) ? MinValue : MaxValue;
               hi = $urandom_range(0, 1) ? MinValue : MaxValue;
            end
         endcase
         if ($urandom_range(0, 1)) begin
            write_bound(psrc_pkg::CsrLowerBound, lo);
            write_bound(psrc_pkg::CsrUpperBound, hi);
         end else begin
            write_bound(psrc_pkg::CsrUpperBound, hi);
            write_bound(psrc_pkg::CsrLowerBound, lo);
         end

         spread    = spread_type'($urandom_range(0, 2));
         feed_gaps = sent < CalmAfter && $urandom_range(0, 3) != 0;
         rsp_gaps  = sent < CalmAfter && $urandom_range(0, 3) != 0;
         sets      = $urandom_range(2, 8);
         repeat (sets) begin
            // now and then a set near capacity: below, at or beyond it
            if ($urandom_range(0, 19) == 0) len = $urandom_range(MaxItems - 8, MaxItems + 8);
            else len = $urandom_range(1, 20);
            run_set(len, spread);
         end
         hold_feed();
         settle();
      end

      // a set that never gets its last mark produces no result
      feed_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      repeat (3) send_value(pick_value(AnyValue), 1'b0);
      hold_feed();
      settle();

      if (ledger.failures == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
